FILE: design/lsf_pkg.sv
// Shared constants for the least-squares line fit block.
`default_nettype none
package lsf_pkg;

  localparam int COORD_W = 16;  // width of one point coordinate
  localparam int FRAC_W  = 16;  // fraction bits of the Q16.16 results
  localparam int RES_W   = 32;  // width of slope and intercept
  localparam int USED_W  = 9;   // width of the reported point count

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

endpackage
`default_nettype wire

FILE: design/lsf_accum.sv
// Point accumulator: count, sum x, sum y, sum x*x and sum x*y, with drop flag.
`default_nettype none
module lsf_accum #(
  parameter int MAX_POINTS = 256,
  parameter int CW         = 9,
  parameter int SXW        = 25,
  parameter int SXXW       = 41
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                step,
  input  wire logic                                clear,
  input  wire logic signed [lsf_pkg::COORD_W-1:0]  x,
  input  wire logic signed [lsf_pkg::COORD_W-1:0]  y,
  output logic             [CW-1:0]                cnt,
  output logic signed      [SXW-1:0]               sx,
  output logic signed      [SXW-1:0]               sy,
  output logic signed      [SXXW-1:0]              sxx,
  output logic signed      [SXXW-1:0]              sxy,
  output logic                                     dropped
);

  logic             [CW-1:0]                  cnt_r;
  logic signed      [SXW-1:0]                 sx_r;
  logic signed      [SXW-1:0]                 sy_r;
  logic signed      [SXXW-1:0]                sxx_r;
  logic signed      [SXXW-1:0]                sxy_r;
  logic                                       drop_r;
  logic signed      [2*lsf_pkg::COORD_W-1:0]  xx;
  logic signed      [2*lsf_pkg::COORD_W-1:0]  xy;
  logic                                       has_room;

  assign xx       = x * x;
  assign xy       = x * y;
  assign has_room = cnt_r < CW'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cnt_r  <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      sxx_r  <= '0;
      sxy_r  <= '0;
      drop_r <= 1'b0;
    end else if (step) begin
      if (has_room) begin
        cnt_r <= cnt_r + 1'b1;
        sx_r  <= sx_r + SXW'(x);
        sy_r  <= sy_r + SXW'(y);
        sxx_r <= sxx_r + SXXW'(xx);
        sxy_r <= sxy_r + SXXW'(xy);
      end else begin
        drop_r <= 1'b1;
      end
    end
  end

  assign cnt     = cnt_r;
  assign sx      = sx_r;
  assign sy      = sy_r;
  assign sxx     = sxx_r;
  assign sxy     = sxy_r;
  assign dropped = drop_r;

endmodule
`default_nettype wire

FILE: design/lsf_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module lsf_mul #(
  parameter int AW = 41,
  parameter int BW = 25
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [AW-1:0]    a,
  input  wire logic signed [BW-1:0]    b,
  output logic                         done,
  output logic signed      [AW+BW-1:0] product
);

  localparam int PW  = AW + BW;
  localparam int CTW = $clog2(BW + 1);

  logic             [CTW-1:0] cnt_r;
  logic                       fin_r;
  logic                       done_r;
  logic                       neg_r;
  logic             [AW-1:0]  ma_r;
  logic             [PW-1:0]  acc_r;
  logic signed      [PW-1:0]  res_r;
  logic             [AW-1:0]  a_mag;
  logic             [BW-1:0]  b_mag;
  logic             [AW:0]    part;

  assign a_mag = a[AW-1] ? AW'(-a) : AW'(a);
  assign b_mag = b[BW-1] ? BW'(-b) : BW'(b);

  // upper half plus multiplicand when the current multiplier bit is set
  assign part = {1'b0, acc_r[PW-1:BW]} + (acc_r[0] ? {1'b0, ma_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= (cnt_r == CTW'(1));
      if (start) begin
        cnt_r <= CTW'(BW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= a_mag;
      neg_r <= a[AW-1] ^ b[BW-1];
      acc_r <= {{AW{1'b0}}, b_mag};
    end else if (cnt_r != '0) begin
      acc_r <= {part, acc_r[BW-1:1]};
    end
    if (fin_r) begin
      res_r <= neg_r ? -$signed(acc_r) : $signed(acc_r);
    end
  end

  assign done    = done_r;
  assign product = res_r;

endmodule
`default_nettype wire

FILE: design/lsf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none
module lsf_div #(
  parameter int DVW = 83,
  parameter int DSW = 67
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVW-1:0]   dividend,
  input  wire logic [DSW-1:0]   divisor,
  output logic                  done,
  output logic      [DVW-1:0]   quotient
);

  localparam int CTW = $clog2(DVW + 1);

  logic [CTW-1:0] cnt_r;
  logic           done_r;
  logic [DSW-1:0] den_r;
  logic [DSW-1:0] rem_r;
  logic [DVW-1:0] qd_r;
  logic [DSW:0]   trial;
  logic           fits;
  logic [DSW:0]   diff;

  // dividend bits shift out of qd_r at the top while quotient bits enter at the bottom
  assign trial = {rem_r, qd_r[DVW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CTW'(1));
      if (start) begin
        cnt_r <= CTW'(DVW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      rem_r <= '0;
      qd_r  <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[DSW-1:0] : trial[DSW-1:0];
      qd_r  <= {qd_r[DVW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = qd_r;

endmodule
`default_nettype wire

FILE: design/least_squares_line_fit_core.sv
// Top level of the streaming least-squares line fit.
`default_nettype none
// Points (x, y) are taken one per cycle while in_stall is low and folded into the
// count and the sums Sx, Sy, Sxx and Sxy. A transaction with last_point set starts
// the fit; from then on in_stall stays high until the result is placed in the output
// register, also while that register still holds an unaccepted result. The fit runs
// on one shared bit-serial multiplier (five products) and one shared bit-serial
// restoring divider (two quotients; the slope quotient is skipped when the
// denominator is zero), with BW = 16+CW, DVW = 65+2*CW and CW = clog2(MAX_POINTS+1).
// Slope and intercept are Q16.16, truncated toward zero and saturated; the
// intercept uses the slope as reported. A zero denominator reports slope 0,
// intercept mean y and sets degenerate. Points past MAX_POINTS are dropped and
// set overflowed. The output register lets a new set start while the previous
// result waits.
module least_squares_line_fit_core #(
  parameter int MAX_POINTS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [lsf_pkg::COORD_W-1:0]  in_x_value,
  input  wire logic signed [lsf_pkg::COORD_W-1:0]  in_y_value,
  input  wire logic                                in_last_point,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [lsf_pkg::RES_W-1:0]    out_slope_out,
  output logic signed      [lsf_pkg::RES_W-1:0]    out_intercept_out,
  output logic             [lsf_pkg::USED_W-1:0]   out_points_used,
  output logic                                     out_degenerate,
  output logic                                     out_overflowed
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int SXW  = lsf_pkg::COORD_W + CW;
  localparam int SXXW = 2 * lsf_pkg::COORD_W + CW;
  localparam int AW   = SXXW;
  localparam int BW   = SXW;
  localparam int PW   = AW + BW;
  localparam int NUMW = PW + 1;
  localparam int DVW  = NUMW + lsf_pkg::FRAC_W;
  localparam int DSW  = NUMW;
  localparam int RW   = lsf_pkg::RES_W;

  localparam logic [DVW-1:0] Q_LIM = {{(DVW-RW){1'b0}}, 1'b1, {(RW-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MSTART = 11'b000_0000_0010,
    S_MWAIT  = 11'b000_0000_0100,
    S_SDIV   = 11'b000_0000_1000,
    S_SWAIT  = 11'b000_0001_0000,
    S_IMUL   = 11'b000_0010_0000,
    S_IMWAIT = 11'b000_0100_0000,
    S_IDIV   = 11'b000_1000_0000,
    S_IWAIT  = 11'b001_0000_0000,
    S_DONE   = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } fit_state_t;

  // magnitude quotient to signed Q16.16 with saturation
  function automatic logic signed [RW-1:0] sat_q(input logic neg, input logic [DVW-1:0] q);
    logic signed [RW-1:0] res;
    if (neg) begin
      res = (q > Q_LIM) ? lsf_pkg::RES_MIN : -$signed(q[RW-1:0]);
    end else begin
      res = (q >= Q_LIM) ? lsf_pkg::RES_MAX : $signed(q[RW-1:0]);
    end
    return res;
  endfunction

  fit_state_t               state_r;
  fit_state_t               state_nxt;
  logic        [1:0]        prod_idx_r;
  logic        [1:0]        prod_idx_nxt;
  logic signed [PW-1:0]     tmp_r;
  logic signed [NUMW-1:0]   num_r;
  logic signed [NUMW-1:0]   den_r;
  logic signed [NUMW-1:0]   t_r;
  logic signed [RW-1:0]     slope_r;
  logic signed [RW-1:0]     icpt_r;
  logic                     degen_r;
  logic                     out_valid_r;
  logic signed [RW-1:0]     out_slope_r;
  logic signed [RW-1:0]     out_icpt_r;
  logic [lsf_pkg::USED_W-1:0] out_used_r;
  logic                     out_degen_r;
  logic                     out_ovf_r;

  logic                     in_acc;
  logic                     out_load;
  logic [CW-1:0]            acc_cnt;
  logic signed [SXW-1:0]    acc_sx;
  logic signed [SXW-1:0]    acc_sy;
  logic signed [SXXW-1:0]   acc_sxx;
  logic signed [SXXW-1:0]   acc_sxy;
  logic                     acc_dropped;
  logic                     mul_start;
  logic signed [AW-1:0]     mul_a;
  logic signed [BW-1:0]     mul_b;
  logic                     mul_done;
  logic signed [PW-1:0]     mul_p;
  logic                     div_start;
  logic [DVW-1:0]           div_dvd;
  logic [DSW-1:0]           div_dsr;
  logic                     div_done;
  logic [DVW-1:0]           div_q;
  logic signed [BW-1:0]     n_b;
  logic                     den_le0;
  logic [NUMW-1:0]          num_mag;
  logic [NUMW-1:0]          t_mag;
  logic [CW+lsf_pkg::USED_W-1:0] cnt_ext;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  lsf_accum #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (CW),
    .SXW        (SXW),
    .SXXW       (SXXW)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_acc),
    .clear   (out_load),
    .x       (in_x_value),
    .y       (in_y_value),
    .cnt     (acc_cnt),
    .sx      (acc_sx),
    .sy      (acc_sy),
    .sxx     (acc_sxx),
    .sxy     (acc_sxy),
    .dropped (acc_dropped)
  );

  assign n_b     = $signed({{(BW-CW){1'b0}}, acc_cnt});
  assign den_le0 = den_r[NUMW-1] || (den_r == '0);
  assign num_mag = num_r[NUMW-1] ? NUMW'(-num_r) : NUMW'(num_r);
  assign t_mag   = t_r[NUMW-1] ? NUMW'(-t_r) : NUMW'(t_r);
  assign cnt_ext = {{lsf_pkg::USED_W{1'b0}}, acc_cnt};

  // operand selection for the shared multiplier
  always_comb begin
    mul_start = (state_r == S_MSTART) || (state_r == S_IMUL);
    if (state_r == S_IMUL) begin
      mul_a = AW'(slope_r);
      mul_b = acc_sx;
    end else begin
      unique case (prod_idx_r)
        2'd0: begin
          mul_a = acc_sxy;
          mul_b = n_b;
        end
        2'd1: begin
          mul_a = AW'(acc_sx);
          mul_b = acc_sy;
        end
        2'd2: begin
          mul_a = acc_sxx;
          mul_b = n_b;
        end
        default: begin
          mul_a = AW'(acc_sx);
          mul_b = acc_sx;
        end
      endcase
    end
  end

  lsf_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // slope: |num| * 2^16 / den; intercept: |Sy*2^16 - slope*Sx| / n
  always_comb begin
    div_start = ((state_r == S_SDIV) && !den_le0) || (state_r == S_IDIV);
    if (state_r == S_SDIV) begin
      div_dvd = {num_mag, {lsf_pkg::FRAC_W{1'b0}}};
      div_dsr = DSW'(den_r);
    end else begin
      div_dvd = DVW'(t_mag);
      div_dsr = {{(DSW-CW){1'b0}}, acc_cnt};
    end
  end

  lsf_div #(
    .DVW (DVW),
    .DSW (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt    = state_r;
    prod_idx_nxt = prod_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_last_point) begin
          state_nxt    = S_MSTART;
          prod_idx_nxt = 2'd0;
        end
      end
      S_MSTART: state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          if (prod_idx_r == 2'd3) begin
            state_nxt = S_SDIV;
          end else begin
            state_nxt    = S_MSTART;
            prod_idx_nxt = prod_idx_r + 2'd1;
          end
        end
      end
      S_SDIV: state_nxt = den_le0 ? S_IMUL : S_SWAIT;
      S_SWAIT: begin
        if (div_done) begin
          state_nxt = S_IMUL;
        end
      end
      S_IMUL: state_nxt = S_IMWAIT;
      S_IMWAIT: begin
        if (mul_done) begin
          state_nxt = S_IDIV;
        end
      end
      S_IDIV: state_nxt = S_IWAIT;
      S_IWAIT: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prod_idx_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prod_idx_r <= prod_idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_MWAIT) && mul_done) begin
      unique case (prod_idx_r)
        2'd0: tmp_r <= mul_p;
        2'd1: num_r <= NUMW'(tmp_r) - NUMW'(mul_p);
        2'd2: tmp_r <= mul_p;
        default: den_r <= NUMW'(tmp_r) - NUMW'(mul_p);
      endcase
    end
    if (state_r == S_SDIV) begin
      degen_r <= den_le0;
      if (den_le0) begin
        slope_r <= '0;
      end
    end
    if ((state_r == S_SWAIT) && div_done) begin
      slope_r <= sat_q(num_r[NUMW-1], div_q);
    end
    if ((state_r == S_IMWAIT) && mul_done) begin
      t_r <= (NUMW'(acc_sy) <<< lsf_pkg::FRAC_W) - NUMW'(mul_p);
    end
    if ((state_r == S_IWAIT) && div_done) begin
      icpt_r <= sat_q(t_r[NUMW-1], div_q);
    end
    if (out_load) begin
      out_slope_r <= slope_r;
      out_icpt_r  <= icpt_r;
      out_used_r  <= cnt_ext[lsf_pkg::USED_W-1:0];
      out_degen_r <= degen_r;
      out_ovf_r   <= acc_dropped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slope_out     = out_slope_r;
  assign out_intercept_out = out_icpt_r;
  assign out_points_used   = out_used_r;
  assign out_degenerate    = out_degen_r;
  assign out_overflowed    = out_ovf_r;

endmodule
`default_nettype wire

FILE: test/tb_least_squares_line_fit_core.sv
`timescale 1ns / 1ps
// Testbench for least_squares_line_fit_core: directed and random point sets vs a predictor.
module tb_least_squares_line_fit_core;

  localparam int CAPACITY     = 256;
  localparam int SMALL_SETS   = 40;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES  = 2000;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef logic signed [lsf_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [lsf_pkg::RES_W-1:0] slope;
    logic signed [lsf_pkg::RES_W-1:0] intercept;
    logic [lsf_pkg::USED_W-1:0]       used;
    logic                             degen;
    logic                             ovf;
  } fit_result_t;

  typedef struct {
    coord_t      x;
    coord_t      y;
    bit          last;
    bit          typed;
    fit_result_t fit;
  } point_row_t;

  typedef enum int {FULL_RANGE, TINY, SAME_X, NEAR_LINE, CORNERS, STEEP} set_kind_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  coord_t in_x_value;
  coord_t in_y_value;
  logic   in_last_point;
  logic   out_stall;
  wire    in_stall;
  wire    out_valid;
  wire signed [lsf_pkg::RES_W-1:0] out_slope_out;
  wire signed [lsf_pkg::RES_W-1:0] out_intercept_out;
  wire [lsf_pkg::USED_W-1:0]       out_points_used;
  wire                             out_degenerate;
  wire                             out_overflowed;

  least_squares_line_fit_core #(.MAX_POINTS(CAPACITY)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_x_value       (in_x_value),
    .in_y_value       (in_y_value),
    .in_last_point    (in_last_point),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slope_out    (out_slope_out),
    .out_intercept_out(out_intercept_out),
    .out_points_used  (out_points_used),
    .out_degenerate   (out_degenerate),
    .out_overflowed   (out_overflowed)
  );

  // running sums of the set being predicted
  int     fit_pts;
  longint fit_sx;
  longint fit_sy;
  longint fit_sxx;
  longint fit_sxy;
  bit     fit_dropped;

  fit_result_t pending_fits[$];
  int          error_count = 0;
  int          fits_seen = 0;
  int          points_sent;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          steady_sender;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Folds one point into the sums; on the last point returns 1 with the fit.
  function automatic bit fold_point(input coord_t x, input coord_t y, input bit last,
                                    output fit_result_t res);
    longint n;
    longint num;
    longint den;
    longint icpt;
    logic [127:0] mag;
    logic [127:0] quo;
    logic signed [lsf_pkg::RES_W-1:0] slope;
    res = '0;
    if (fit_pts < CAPACITY) begin
      fit_pts++;
      fit_sx  += x;
      fit_sy  += y;
      fit_sxx += longint'(x) * longint'(x);
      fit_sxy += longint'(x) * longint'(y);
    end else begin
      fit_dropped = 1'b1;
    end
    if (!last) return 1'b0;
    n   = fit_pts;
    num = n * fit_sxy - fit_sx * fit_sy;
    den = n * fit_sxx - fit_sx * fit_sx;
    if (den <= 0) begin
      slope = '0;
    end else begin
      mag = (num < 0) ? 128'(-num) : 128'(num);
      quo = (mag << lsf_pkg::FRAC_W) / 128'(den);
      if (quo > 128'(lsf_pkg::RES_MAX)) begin
        slope = (num < 0) ? lsf_pkg::RES_MIN : lsf_pkg::RES_MAX;
      end else begin
        slope = (num < 0) ? -quo[lsf_pkg::RES_W-1:0] : quo[lsf_pkg::RES_W-1:0];
      end
    end
    // intercept is built from the slope as reported
    icpt = (fit_sy * 65536 - longint'(slope) * fit_sx) / n;
    if (icpt > longint'(lsf_pkg::RES_MAX)) res.intercept = lsf_pkg::RES_MAX;
    else if (icpt < longint'(lsf_pkg::RES_MIN)) res.intercept = lsf_pkg::RES_MIN;
    else res.intercept = icpt[lsf_pkg::RES_W-1:0];
    res.slope = slope;
    res.used  = fit_pts[lsf_pkg::USED_W-1:0];
    res.degen = (den <= 0);
    res.ovf   = fit_dropped;
    fit_pts     = 0;
    fit_sx      = 0;
    fit_sy      = 0;
    fit_sxx     = 0;
    fit_sxy     = 0;
    fit_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic point_row_t pt(input coord_t x, input coord_t y, input bit last);
    point_row_t r;
    r.x     = x;
    r.y     = y;
    r.last  = last;
    r.typed = 1'b0;
    r.fit   = '0;
    return r;
  endfunction

  // last point of a set whose fit is known by hand
  function automatic point_row_t pt_fit(input coord_t x, input coord_t y,
                                        input logic signed [lsf_pkg::RES_W-1:0] slope,
                                        input logic signed [lsf_pkg::RES_W-1:0] icpt,
                                        input logic [lsf_pkg::USED_W-1:0] used,
                                        input logic degen);
    point_row_t r;
    r.x     = x;
    r.y     = y;
    r.last  = 1'b1;
    r.typed = 1'b1;
    r.fit   = '{slope, icpt, used, degen, 1'b0};
    return r;
  endfunction

  function automatic coord_t corner_coord();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic offer_point(input coord_t x, input coord_t y, input bit last,
                             input bit typed, input fit_result_t typed_fit);
    fit_result_t fit;
    if (!steady_sender && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_x_value    <= x;
    in_y_value    <= y;
    in_last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fold_point(x, y, last, fit)) pending_fits.push_back(typed ? typed_fit : fit);
    points_sent++;
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_fit();
    fit_result_t want;
    if (pending_fits.size() == 0) begin
      $display("%0t: unexpected transaction, expected none, got slope %0d intercept %0d",
               $time, out_slope_out, out_intercept_out);
      error_count++;
    end else begin
      want = pending_fits.pop_front();
      compare_field("slope", want.slope, out_slope_out);
      compare_field("intercept", want.intercept, out_intercept_out);
      compare_field("points_used", want.used, out_points_used);
      compare_field("degenerate", want.degen, out_degenerate);
      compare_field("overflowed", want.ovf, out_overflowed);
    end
    fits_seen++;
  endtask

  // result side: random stalls, one long hold-off, one stretch with no stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_fit();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && fits_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (fits_seen >= 30 && fits_seen < 45) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 14);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[least_squares_line_fit_core] ERROR");
    $finish;
  end

  initial begin
    point_row_t  rows[$];
    set_kind_t   kind;
    int          set_len;
    int          xi;
    int          slope_k;
    int          offset_k;
    coord_t      x;
    coord_t      y;
    coord_t      fixed_x;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_x_value    <= '0;
    in_y_value    <= '0;
    in_last_point <= 1'b0;
    fit_pts       = 0;
    fit_sx        = 0;
    fit_sy        = 0;
    fit_sxx       = 0;
    fit_sxy       = 0;
    fit_dropped   = 1'b0;
    points_sent   = 0;
    steady_sender = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    rows = '{
      // single points: no spread in x, intercept is the lone y
      pt_fit(16'sd5, 16'sd7, 32'sd0, 32'sd458752, 9'd1, 1'b1),
      pt_fit(16'sh8000, 16'sh8000, 32'sd0, lsf_pkg::RES_MIN, 9'd1, 1'b1),
      pt_fit(16'sh7FFF, 16'sh7FFF, 32'sd0, 32'sh7FFF0000, 9'd1, 1'b1),
      // unit slope through the origin
      pt(16'sd0, 16'sd0, 1'b0),
      pt_fit(16'sd1, 16'sd1, 32'sh00010000, 32'sd0, 9'd2, 1'b0),
      // slope saturates high, then low
      pt(16'sd0, 16'sh8000, 1'b0),
      pt(16'sd1, 16'sh7FFF, 1'b1),
      pt(16'sd0, 16'sh7FFF, 1'b0),
      pt(16'sd1, 16'sh8000, 1'b1),
      // all x equal: zero denominator, mean y
      pt(16'sd3, 16'sd10, 1'b0),
      pt(16'sd3, 16'sd20, 1'b0),
      pt_fit(16'sd3, -16'sd6, 32'sd0, 32'sd524288, 9'd3, 1'b1),
      pt(16'sd100, 16'sd1, 1'b0),
      pt_fit(16'sd100, 16'sd2, 32'sd0, 32'sd98304, 9'd2, 1'b1),
      // widest spread of x and y
      pt(16'sh8000, 16'sh7FFF, 1'b0),
      pt(16'sh7FFF, 16'sh8000, 1'b0),
      pt(16'sd0, 16'sd0, 1'b1),
      // negative mean truncates toward zero
      pt(16'sd2, -16'sd1, 1'b0),
      pt(16'sd2, 16'sd0, 1'b0),
      pt_fit(16'sd2, 16'sd0, 32'sd0, -32'sd21845, 9'd3, 1'b1),
      // slope of one third, both signs
      pt(16'sd0, 16'sd0, 1'b0),
      pt_fit(16'sd3, 16'sd1, 32'sd21845, 32'sd0, 9'd2, 1'b0),
      pt(16'sd0, 16'sd0, 1'b0),
      pt_fit(16'sd3, -16'sd1, -32'sd21845, 32'sd0, 9'd2, 1'b0)
    };
    foreach (rows[i]) offer_point(rows[i].x, rows[i].y, rows[i].last, rows[i].typed,
                                  rows[i].fit);

    for (int s = 0; s < SMALL_SETS + 3; s++) begin
      // a full set, one that drops its last point, and one that drops several
      if (s == 8 || s == 25 || s == 38) begin
        set_len = (s == 8) ? CAPACITY : (s == 25) ? CAPACITY + 1 : CAPACITY + 7;
        kind    = ($urandom_range(1) == 0) ? FULL_RANGE : CORNERS;
      end else begin
        set_len = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 24);
        kind    = set_kind_t'($urandom_range(5));
      end
      fixed_x  = coord_t'($urandom);
      slope_k  = int'($urandom_range(8)) - 4;
      offset_k = int'($urandom_range(200)) - 100;
      for (int i = 0; i < set_len; i++) begin
        steady_sender = (points_sent >= 300 && points_sent < 500);
        case (kind)
          FULL_RANGE: begin
            x = coord_t'($urandom);
            y = coord_t'($urandom);
          end
          TINY: begin
            x = coord_t'(int'($urandom_range(16)) - 8);
            y = coord_t'(int'($urandom_range(16)) - 8);
          end
          SAME_X: begin
            x = fixed_x;
            y = coord_t'($urandom);
          end
          NEAR_LINE: begin
            xi = int'($urandom_range(400)) - 200;
            x  = coord_t'(xi);
            y  = coord_t'(slope_k * xi + offset_k + int'($urandom_range(6)) - 3);
          end
          CORNERS: begin
            x = corner_coord();
            y = corner_coord();
          end
          default: begin
            x = coord_t'($urandom_range(1));
            y = coord_t'($urandom);
          end
        endcase
        offer_point(x, y, i == set_len - 1, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_fits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[least_squares_line_fit_core] OK");
    end else begin
      $display("[least_squares_line_fit_core] ERROR");
    end
    $finish;
  end

endmodule
